/* src/cop_pkg.sv */
// shared types and constants for the coap option parser
`default_nettype none

package cop_pkg;

  localparam int unsigned ValW = 17;

  localparam logic [7:0]      PayloadMarker = 8'hFF;
  localparam logic [3:0]      NibReserved   = 4'd15;
  localparam logic [3:0]      NibExt16      = 4'd14;
  localparam logic [3:0]      NibExt8       = 4'd13;
  localparam logic [ValW-1:0] Ext8Base      = 17'd13;
  localparam logic [ValW-1:0] Ext16Base     = 17'd269;

  typedef enum logic [2:0] {
    PH_STOP = 3'd0,
    PH_HDR  = 3'd1,
    PH_DHI  = 3'd2,
    PH_DLO  = 3'd3,
    PH_LHI  = 3'd4,
    PH_LLO  = 3'd5,
    PH_VAL  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_VALUE  = 2'd1,
    KIND_STOP   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_PAYLOAD    = 3'd1,
    ST_RSV_DELTA  = 3'd2,
    ST_RSV_LENGTH = 3'd3,
    ST_TRUNC_HDR  = 3'd4,
    ST_TRUNC_VAL  = 3'd5
  } status_t;

  typedef struct packed {
    phase_t          phase;
    logic [ValW-1:0] delta_acc;
    logic [ValW-1:0] length_acc;
    logic [3:0]      length_nibble;
    logic [ValW-1:0] value_left;
    logic [2:0]      header_count;
  } state_t;

  typedef struct packed {
    kind_t           kind;
    logic [ValW-1:0] option_delta;
    logic [ValW-1:0] option_length;
    logic [ValW-1:0] option_size;
    logic [7:0]      value_byte;
    logic            value_last;
    status_t         status;
  } res_t;

endpackage

`default_nettype wire

/* src/cop_in_if.sv */
// input channel: one option list byte per transfer
`default_nettype none

interface cop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;
  logic       restart;

  modport source(output valid, output data_byte, output end_of_buffer, output restart,
                 input ready);
  modport sink(input valid, input data_byte, input end_of_buffer, input restart,
               output ready);
endinterface

`default_nettype wire

/* src/cop_out_if.sv */
// result channel: header, value byte or stop report per transfer
`default_nettype none

interface cop_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [16:0] option_delta;
  logic [16:0] option_length;
  logic [16:0] option_size;
  logic [7:0]  value_byte;
  logic        value_last;
  logic [2:0]  status;

  modport source(output valid, output kind, output option_delta, output option_length,
                 output option_size, output value_byte, output value_last,
                 output status, input ready);
  modport sink(input valid, input kind, input option_delta, input option_length,
               input option_size, input value_byte, input value_last, input status,
               output ready);
endinterface

`default_nettype wire

/* src/cop_step.sv */
// per-byte parser step: next state and optional result
`default_nettype none

module cop_step import cop_pkg::*; (
  input  state_t     st,
  input  logic [7:0] data_byte,
  input  logic       eob,
  input  logic       restart,
  output state_t     st_next,
  output logic       res_valid,
  output res_t       res
);

  phase_t         ph;
  logic           go_after_delta;
  logic           go_header_done;
  logic           go_need_more;
  logic [3:0]     dn;
  logic           last;

  assign ph   = restart ? PH_HDR : st.phase;
  assign dn   = data_byte[7:4];
  assign last = (st.value_left <= 17'd1);

  always_comb begin
    st_next        = st;
    st_next.phase  = ph;
    res_valid      = 1'b0;
    res            = '0;
    res.kind       = KIND_HEADER;
    res.status     = ST_OK;
    go_after_delta = 1'b0;
    go_header_done = 1'b0;
    go_need_more   = 1'b0;

    unique case (ph)
      PH_HDR: begin
        st_next.header_count  = 3'd1;
        st_next.length_nibble = data_byte[3:0];
        if (data_byte == PayloadMarker) begin
          st_next.phase = PH_STOP;
          res_valid     = 1'b1;
          res.kind      = KIND_STOP;
          res.status    = ST_PAYLOAD;
        end else if (dn == NibReserved) begin
          st_next.phase = PH_STOP;
          res_valid     = 1'b1;
          res.kind      = KIND_STOP;
          res.status    = ST_RSV_DELTA;
        end else if (dn == NibExt16) begin
          st_next.phase = PH_DHI;
          go_need_more  = 1'b1;
        end else if (dn == NibExt8) begin
          st_next.delta_acc = Ext8Base;
          st_next.phase     = PH_DLO;
          go_need_more      = 1'b1;
        end else begin
          st_next.delta_acc = {13'd0, dn};
          go_after_delta    = 1'b1;
        end
      end
      PH_DHI: begin
        st_next.header_count = st.header_count + 3'd1;
        st_next.delta_acc    = {1'b0, data_byte, 8'd0} + Ext16Base;
        st_next.phase        = PH_DLO;
        go_need_more         = 1'b1;
      end
      PH_DLO: begin
        st_next.header_count = st.header_count + 3'd1;
        st_next.delta_acc    = st.delta_acc + {9'd0, data_byte};
        go_after_delta       = 1'b1;
      end
      PH_LHI: begin
        st_next.header_count = st.header_count + 3'd1;
        st_next.length_acc   = {1'b0, data_byte, 8'd0} + Ext16Base;
        st_next.phase        = PH_LLO;
        go_need_more         = 1'b1;
      end
      PH_LLO: begin
        st_next.header_count = st.header_count + 3'd1;
        st_next.length_acc   = st.length_acc + {9'd0, data_byte};
        go_header_done       = 1'b1;
      end
      PH_VAL: begin
        if (!last && eob) begin
          st_next.phase = PH_STOP;
          res_valid     = 1'b1;
          res.kind      = KIND_STOP;
          res.status    = ST_TRUNC_VAL;
        end else begin
          st_next.value_left = last ? '0 : st.value_left - 17'd1;
          res_valid          = 1'b1;
          res.kind           = KIND_VALUE;
          res.option_delta   = st.delta_acc;
          res.option_length  = st.length_acc;
          res.value_byte     = data_byte;
          res.value_last     = last;
          if (last) begin
            st_next.phase = eob ? PH_STOP : PH_HDR;
          end
        end
      end
      default: begin
        st_next.phase = PH_STOP;
      end
    endcase

    // length nibble decode once the delta is known
    if (go_after_delta) begin
      if (st_next.length_nibble == NibReserved) begin
        st_next.phase = PH_STOP;
        res_valid     = 1'b1;
        res.kind      = KIND_STOP;
        res.status    = ST_RSV_LENGTH;
      end else if (st_next.length_nibble == NibExt16) begin
        st_next.phase = PH_LHI;
        go_need_more  = 1'b1;
      end else if (st_next.length_nibble == NibExt8) begin
        st_next.length_acc = Ext8Base;
        st_next.phase      = PH_LLO;
        go_need_more       = 1'b1;
      end else begin
        st_next.length_acc = {13'd0, st_next.length_nibble};
        go_header_done     = 1'b1;
      end
    end

    // header complete: report it unless its value is cut off
    if (go_header_done) begin
      if (st_next.length_acc != '0 && eob) begin
        st_next.phase = PH_STOP;
        res_valid     = 1'b1;
        res.kind      = KIND_STOP;
        res.status    = ST_TRUNC_VAL;
      end else begin
        res_valid         = 1'b1;
        res.kind          = KIND_HEADER;
        res.option_delta  = st_next.delta_acc;
        res.option_length = st_next.length_acc;
        res.option_size   = {14'd0, st_next.header_count} + st_next.length_acc;
        if (st_next.length_acc == '0) begin
          st_next.phase = eob ? PH_STOP : PH_HDR;
        end else begin
          st_next.value_left = st_next.length_acc;
          st_next.phase      = PH_VAL;
        end
      end
    end

    if (go_need_more && eob) begin
      st_next.phase = PH_STOP;
      res_valid     = 1'b1;
      res.kind      = KIND_STOP;
      res.status    = ST_TRUNC_HDR;
    end
  end

endmodule

`default_nettype wire

/* src/coap_option_parser.sv */
// top level of the streaming coap option list parser
`default_nettype none

// Streaming CoAP option list parser. Option list bytes arrive one per transfer on
// the data channel; each byte is parsed for its delta and length nibbles and their
// 8-bit or 16-bit extensions (nibble 13 adds 13, nibble 14 adds 269). A completed
// header is reported with its decoded delta, length and total size (header bytes
// plus value length), each value byte is passed through with value_last on the
// final one, and a stop report carries the reason: payload marker 0xFF, reserved
// nibble 15, or a buffer that ends inside a header or value. After a stop, bytes
// are dropped silently until one arrives with restart set; restart is honored in
// any phase and abandons the option in progress. At most one result per byte;
// bytes that only advance the header produce none. The block takes one byte per
// cycle sustained while the result channel is not stalling: a byte is captured in an
// input register, the parser state is updated by a single pass through the step
// logic, and any result lands in an output register, which drives result valid.
// The input register drains into the step logic whenever the output register is
// empty or being taken, so back-pressure on the result channel stalls the data
// channel by at most that one stage.
module coap_option_parser import cop_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cop_in_if.sink    data,
  cop_out_if.source result
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eob;
  logic       s1_restart;
  logic       s1_fire;

  // parser state
  state_t     st;
  state_t     st_next;

  // step result and output register
  logic       step_valid;
  res_t       step_res;
  logic       s2_valid;
  res_t       s2_res;

  // input register advances when the output side can take its result
  assign s1_fire    = s1_valid && (!s2_valid || result.ready);
  assign data.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (data.ready) begin
      s1_valid <= data.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data.valid && data.ready) begin
      s1_byte    <= data.data_byte;
      s1_eob     <= data.end_of_buffer;
      s1_restart <= data.restart;
    end
  end

  cop_step u_step (
    .st        (st),
    .data_byte (s1_byte),
    .eob       (s1_eob),
    .restart   (s1_restart),
    .st_next   (st_next),
    .res_valid (step_valid),
    .res       (step_res)
  );

  // state only moves when a byte goes through the step logic
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase         <= PH_STOP;
      st.delta_acc     <= '0;
      st.length_acc    <= '0;
      st.length_nibble <= '0;
      st.value_left    <= '0;
      st.header_count  <= '0;
    end else if (s1_fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_fire) begin
      s2_valid <= step_valid;
    end else if (result.ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && step_valid) begin
      s2_res <= step_res;
    end
  end

  assign result.valid         = s2_valid;
  assign result.kind          = s2_res.kind;
  assign result.option_delta  = s2_res.option_delta;
  assign result.option_length = s2_res.option_length;
  assign result.option_size   = s2_res.option_size;
  assign result.value_byte    = s2_res.value_byte;
  assign result.value_last    = s2_res.value_last;
  assign result.status        = s2_res.status;

  // a stop report always carries a reason, other results never do
  a_stop_status: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> ((s2_res.kind == KIND_STOP) == (s2_res.status != ST_OK)))
    else $error("stop report and status disagree");

  // value_last only marks value bytes
  a_last_on_value: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_res.value_last) |-> (s2_res.kind == KIND_VALUE))
    else $error("value_last on a non-value result");

  // a new result appears only when a byte went through the step logic
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(s2_valid) |-> $past(s1_fire))
    else $error("result without a parsed byte");

  // a stop report leaves the parser stopped
  a_stop_parks: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && step_valid && step_res.kind == KIND_STOP) |=> (st.phase == PH_STOP))
    else $error("parser not stopped after stop report");

endmodule

`default_nettype wire
